FILE: sv/rtct_pkg.sv
// Shared codes and constants for the radio transmit completion tracker.
`timescale 1ns / 1ps
package rtct_pkg;

  localparam int unsigned TIMEOUT_W = 17;

  localparam logic [7:0] MAX_PAYLOAD = 8'd32;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 17'd20000;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POLL = 2'd1;
  localparam logic [1:0] CMD_ACK  = 2'd2;
  localparam logic [1:0] CMD_NOP  = 2'd3;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_BUSY   = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;
  localparam logic [1:0] PH_FAILED = 2'd3;

  localparam logic [1:0] RC_OK        = 2'd0;
  localparam logic [1:0] RC_BAD_LEN   = 2'd1;
  localparam logic [1:0] RC_FIFO_FULL = 2'd2;

  localparam logic [1:0] DRV_NONE = 2'd0;
  localparam logic [1:0] DRV_LOW  = 2'd1;
  localparam logic [1:0] DRV_HIGH = 2'd2;

  localparam logic [2:0] CLR_NONE   = 3'd0;
  localparam logic [2:0] CLR_MAX_RT = 3'd1;
  localparam logic [2:0] CLR_SENT   = 3'd2;
  localparam logic [2:0] CLR_ALL    = 3'd7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_us;
    logic [7:0]  frame_len;
    logic        fifo_full;
    logic        fifo_empty;
    logic        flag_max_retry;
    logic        flag_sent;
    logic [3:0]  retry_count;
    logic [3:0]  lost_count;
  } in_beat_t;

endpackage

FILE: sv/radio_tx_completion_tracker_top.sv
// Radio transmit completion tracker: input register, event logic, result register.
// Two register stages: an accepted input beat is held in the input register, and its result
// beat is loaded into the result register once the result stage is empty or being drained.
// Throughput: one beat per cycle; the input register and the result register each
// advance whenever the stage after them is empty or being drained.
// Reset (rst, synchronous): phase idle, counters and start time zero, lost latch zero,
// timeout limit back to 20000, both stages empty.
`timescale 1ns / 1ps
module radio_tx_completion_tracker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [rtct_pkg::TIMEOUT_W-1:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] now_us,
  input  logic [7:0]  frame_len,
  input  logic        fifo_full,
  input  logic        fifo_empty,
  input  logic        flag_max_retry,
  input  logic        flag_sent,
  input  logic [3:0]  retry_count,
  input  logic [3:0]  lost_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  tx_status,
  output logic [1:0]  result_code,
  output logic        flush_fifo,
  output logic [1:0]  enable_drive,
  output logic [2:0]  clear_mask,
  output logic [31:0] retransmit_total,
  output logic [31:0] ok_total,
  output logic [31:0] dropped_total,
  output logic [31:0] timeout_total,
  output logic [3:0]  last_lost
);
  import rtct_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_limit;

  logic     in_valid_q;
  in_beat_t in_q;
  logic     out_free;
  logic     in_adv;

  logic [1:0]  phase, phase_next;
  logic [31:0] start_time, start_time_next;
  logic [31:0] retransmits_acc, retransmits_acc_next;
  logic [31:0] ok_acc, ok_acc_next;
  logic [31:0] dropped_acc, dropped_acc_next;
  logic [31:0] timeout_acc, timeout_acc_next;
  logic [3:0]  lost_latch, lost_latch_next;

  logic [1:0]  rc_next;
  logic        flush_next;
  logic [1:0]  drive_next;
  logic [2:0]  clr_next;
  logic [31:0] elapsed;
  logic        timed_out;
  logic        bad_len;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign in_adv    = in_valid_q && out_free;
  assign in_ready  = !in_valid_q || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_limit <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= '{cmd: cmd, now_us: now_us, frame_len: frame_len,
                fifo_full: fifo_full, fifo_empty: fifo_empty,
                flag_max_retry: flag_max_retry, flag_sent: flag_sent,
                retry_count: retry_count, lost_count: lost_count};
    end
  end

  assign elapsed   = in_q.now_us - start_time;
  assign timed_out = elapsed > {{(32-TIMEOUT_W){1'b0}}, timeout_limit};
  assign bad_len   = (in_q.frame_len == 8'd0) || (in_q.frame_len > MAX_PAYLOAD);

  always_comb begin
    phase_next           = phase;
    start_time_next      = start_time;
    retransmits_acc_next = retransmits_acc;
    ok_acc_next          = ok_acc;
    dropped_acc_next     = dropped_acc;
    timeout_acc_next     = timeout_acc;
    lost_latch_next      = lost_latch;
    rc_next              = RC_OK;
    flush_next           = 1'b0;
    drive_next           = DRV_NONE;
    clr_next             = CLR_NONE;
    unique case (in_q.cmd)
      CMD_PUSH: begin
        priority if (bad_len) begin
          rc_next = RC_BAD_LEN;
        end else if (in_q.fifo_full) begin
          rc_next = RC_FIFO_FULL;
        end else begin
          drive_next = DRV_HIGH;
          if (phase != PH_BUSY) begin
            start_time_next = in_q.now_us;
          end
          phase_next = PH_BUSY;
        end
      end
      CMD_POLL: begin
        if (phase == PH_BUSY) begin
          priority if (in_q.flag_max_retry) begin
            retransmits_acc_next = retransmits_acc + {28'd0, in_q.retry_count};
            lost_latch_next      = in_q.lost_count;
            dropped_acc_next     = dropped_acc + 32'd1;
            clr_next             = CLR_MAX_RT;
            flush_next           = 1'b1;
            drive_next           = DRV_LOW;
            phase_next           = PH_FAILED;
          end else if (in_q.flag_sent) begin
            retransmits_acc_next = retransmits_acc + {28'd0, in_q.retry_count};
            ok_acc_next          = ok_acc + 32'd1;
            clr_next             = CLR_SENT;
            if (in_q.fifo_empty) begin
              drive_next = DRV_LOW;
              phase_next = PH_DONE;
            end else begin
              start_time_next = in_q.now_us;
            end
          end else if (timed_out) begin
            timeout_acc_next = timeout_acc + 32'd1;
            flush_next       = 1'b1;
            drive_next       = DRV_LOW;
            clr_next         = CLR_ALL;
            phase_next       = PH_FAILED;
          end
        end
      end
      CMD_ACK: begin
        phase_next = PH_IDLE;
      end
      CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      start_time      <= 32'd0;
      retransmits_acc <= 32'd0;
      ok_acc          <= 32'd0;
      dropped_acc     <= 32'd0;
      timeout_acc     <= 32'd0;
      lost_latch      <= 4'd0;
    end else if (in_adv) begin
      phase           <= phase_next;
      start_time      <= start_time_next;
      retransmits_acc <= retransmits_acc_next;
      ok_acc          <= ok_acc_next;
      dropped_acc     <= dropped_acc_next;
      timeout_acc     <= timeout_acc_next;
      lost_latch      <= lost_latch_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      tx_status        <= phase_next;
      result_code      <= rc_next;
      flush_fifo       <= flush_next;
      enable_drive     <= drive_next;
      clear_mask       <= clr_next;
      retransmit_total <= retransmits_acc_next;
      ok_total         <= ok_acc_next;
      dropped_total    <= dropped_acc_next;
      timeout_total    <= timeout_acc_next;
      last_lost        <= lost_latch_next;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !out_free |=> in_valid_q)
    else $error("input beat dropped while result stage stalled");

  a_flush_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && flush_fifo |-> tx_status == PH_FAILED)
    else $error("flush without failure");

  a_push_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_code != RC_OK |-> enable_drive == DRV_NONE && clear_mask == CLR_NONE)
    else $error("rejected push drove outputs");

  a_high_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && enable_drive == DRV_HIGH |-> tx_status == PH_BUSY)
    else $error("enable high while not busy");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the radio transmit completion tracker.
`timescale 1ns / 1ps
module tb_top;
  import rtct_pkg::*;

  typedef struct packed {
    logic [1:0]  tx_status;
    logic [1:0]  result_code;
    logic        flush_fifo;
    logic [1:0]  enable_drive;
    logic [2:0]  clear_mask;
    logic [31:0] retransmit_total;
    logic [31:0] ok_total;
    logic [31:0] dropped_total;
    logic [31:0] timeout_total;
    logic [3:0]  last_lost;
  } tx_report_t;

  typedef enum {RX_ALWAYS, RX_GAPPY, RX_CHOKED} rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic [TIMEOUT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  in_beat_t src = '0;
  logic out_ready = 1'b0;

  logic        cfg_ready, in_ready, out_valid;
  logic [1:0]  tx_status, result_code, enable_drive;
  logic        flush_fifo;
  logic [2:0]  clear_mask;
  logic [31:0] retransmit_total, ok_total, dropped_total, timeout_total;
  logic [3:0]  last_lost;

  // tracker copy kept by the testbench
  logic [1:0]           trk_phase = PH_IDLE;
  logic [31:0]          trk_start = '0;
  logic [31:0]          retx_sum = '0;
  logic [31:0]          ok_sum = '0;
  logic [31:0]          drop_sum = '0;
  logic [31:0]          tmo_sum = '0;
  logic [3:0]           lost_seen = '0;
  logic [TIMEOUT_W-1:0] tmo_limit = TIMEOUT_RESET;

  tx_report_t  report_q[$];
  tx_report_t  want;
  logic [31:0] t_now = '0;
  int unsigned gap_after = 1;
  int unsigned rx_hold = 0;
  bit          idle_on = 1'b1;
  rx_mode_e    rx_mode = RX_ALWAYS;
  int unsigned beats_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settings_used = 0;
  int unsigned err_count = 0;

  radio_tx_completion_tracker_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (src.cmd),
    .now_us           (src.now_us),
    .frame_len        (src.frame_len),
    .fifo_full        (src.fifo_full),
    .fifo_empty       (src.fifo_empty),
    .flag_max_retry   (src.flag_max_retry),
    .flag_sent        (src.flag_sent),
    .retry_count      (src.retry_count),
    .lost_count       (src.lost_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .tx_status        (tx_status),
    .result_code      (result_code),
    .flush_fifo       (flush_fifo),
    .enable_drive     (enable_drive),
    .clear_mask       (clear_mask),
    .retransmit_total (retransmit_total),
    .ok_total         (ok_total),
    .dropped_total    (dropped_total),
    .timeout_total    (timeout_total),
    .last_lost        (last_lost)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic tx_report_t next_tx_report(in_beat_t b);
    tx_report_t  r;
    logic [31:0] elapsed;
    logic [31:0] limit32;
    r = '0;
    limit32 = tmo_limit;
    elapsed = b.now_us - trk_start;
    case (b.cmd)
      CMD_PUSH: begin
        if (b.frame_len == 8'd0 || b.frame_len > MAX_PAYLOAD) begin
          r.result_code = RC_BAD_LEN;
        end else if (b.fifo_full) begin
          r.result_code = RC_FIFO_FULL;
        end else begin
          r.enable_drive = DRV_HIGH;
          if (trk_phase != PH_BUSY) trk_start = b.now_us;
          trk_phase = PH_BUSY;
        end
      end
      CMD_POLL: begin
        if (trk_phase == PH_BUSY) begin
          if (b.flag_max_retry) begin
            retx_sum = retx_sum + b.retry_count;
            lost_seen = b.lost_count;
            drop_sum = drop_sum + 1;
            r.clear_mask = CLR_MAX_RT;
            r.flush_fifo = 1'b1;
            r.enable_drive = DRV_LOW;
            trk_phase = PH_FAILED;
          end else if (b.flag_sent) begin
            retx_sum = retx_sum + b.retry_count;
            ok_sum = ok_sum + 1;
            r.clear_mask = CLR_SENT;
            if (b.fifo_empty) begin
              r.enable_drive = DRV_LOW;
              trk_phase = PH_DONE;
            end else begin
              trk_start = b.now_us;
            end
          end else if (elapsed > limit32) begin
            tmo_sum = tmo_sum + 1;
            r.flush_fifo = 1'b1;
            r.enable_drive = DRV_LOW;
            r.clear_mask = CLR_ALL;
            trk_phase = PH_FAILED;
          end
        end
      end
      CMD_ACK: trk_phase = PH_IDLE;
      default: ;
    endcase
    r.tx_status = trk_phase;
    r.retransmit_total = retx_sum;
    r.ok_total = ok_sum;
    r.dropped_total = drop_sum;
    r.timeout_total = tmo_sum;
    r.last_lost = lost_seen;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    b.cmd = $urandom_range(0, 3);
    b.now_us = $urandom;
    b.frame_len = $urandom_range(0, 255);
    {b.fifo_full, b.fifo_empty, b.flag_max_retry, b.flag_sent} = $urandom_range(0, 15);
    b.retry_count = $urandom_range(0, 15);
    b.lost_count = $urandom_range(0, 15);
    return b;
  endfunction

  function automatic in_beat_t push_beat(logic [31:0] now, logic [7:0] len, logic full);
    in_beat_t b;
    b = '0;
    b.cmd = CMD_PUSH;
    b.now_us = now;
    b.frame_len = len;
    b.fifo_full = full;
    return b;
  endfunction

  function automatic in_beat_t poll_beat(logic [31:0] now, logic max_rt, logic sent,
                                         logic empty, logic [3:0] retry, logic [3:0] lost);
    in_beat_t b;
    b = '0;
    b.cmd = CMD_POLL;
    b.now_us = now;
    b.flag_max_retry = max_rt;
    b.flag_sent = sent;
    b.fifo_empty = empty;
    b.retry_count = retry;
    b.lost_count = lost;
    return b;
  endfunction

  function automatic in_beat_t cmd_beat(logic [1:0] c, logic [31:0] now);
    in_beat_t b;
    b = '0;
    b.cmd = c;
    b.now_us = now;
    return b;
  endfunction

  // result side: random stalls, then compare against the oldest expectation
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_GAPPY:  rx_hold = pick_gap();
        RX_CHOKED: rx_hold = ($urandom_range(0, 1) == 0) ? $urandom_range(4, 30) : 0;
        default:   rx_hold = 0;
      endcase
      out_ready <= (rx_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (report_q.size() == 0) begin
        err_count++;
        $display("%0t: result beat with nothing expected", $time);
      end else begin
        want = report_q.pop_front();
        check_field("tx_status", want.tx_status, tx_status);
        check_field("result_code", want.result_code, result_code);
        check_field("flush_fifo", want.flush_fifo, flush_fifo);
        check_field("enable_drive", want.enable_drive, enable_drive);
        check_field("clear_mask", want.clear_mask, clear_mask);
        check_field("retransmit_total", want.retransmit_total, retransmit_total);
        check_field("ok_total", want.ok_total, ok_total);
        check_field("dropped_total", want.dropped_total, dropped_total);
        check_field("timeout_total", want.timeout_total, timeout_total);
        check_field("last_lost", want.last_lost, last_lost);
      end
    end
  end

  task automatic send_beat(input in_beat_t b);
    if (gap_after != 0) repeat (gap_after) @(posedge clk);
    in_valid <= 1'b1;
    src <= b;
    do @(posedge clk); while (!in_ready);
    report_q.push_back(next_tx_report(b));
    beats_sent++;
    gap_after = idle_on ? pick_gap() : 0;
    if (gap_after != 0) in_valid <= 1'b0;
  endtask

  task automatic drain_reports();
    int unsigned waited;
    waited = 0;
    if (gap_after == 0) begin
      in_valid <= 1'b0;
      gap_after = 1;
    end
    while (report_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [TIMEOUT_W-1:0] v);
    drain_reports();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tmo_limit = v;
    settings_used++;
  endtask

  // push, a few intermediate beats, one closing poll, usually an acknowledge
  task automatic run_transaction();
    in_beat_t b;
    int unsigned n;
    t_now = t_now + $urandom_range(1, 5000);
    b = rand_beat();
    b.cmd = CMD_PUSH;
    b.frame_len = $urandom_range(1, MAX_PAYLOAD);
    b.fifo_full = 1'b0;
    b.now_us = t_now;
    send_beat(b);
    n = $urandom_range(0, 4);
    repeat (n) begin
      t_now = t_now + $urandom_range(0, tmo_limit / 4);
      b = rand_beat();
      b.now_us = t_now;
      case ($urandom_range(0, 5))
        0: begin
          b.cmd = CMD_PUSH;
          b.frame_len = $urandom_range(1, MAX_PAYLOAD);
          b.fifo_full = 1'b0;
        end
        1: begin
          b.cmd = CMD_PUSH;
          if ($urandom_range(0, 2) == 0) begin
            b.frame_len = 8'd0;
          end else if ($urandom_range(0, 1) == 0) begin
            b.frame_len = $urandom_range(33, 255);
          end else begin
            b.frame_len = $urandom_range(1, MAX_PAYLOAD);
            b.fifo_full = 1'b1;
          end
        end
        2: begin
          b.cmd = CMD_POLL;
          b.flag_max_retry = 1'b0;
          b.flag_sent = 1'b1;
          b.fifo_empty = 1'b0;
        end
        default: begin
          b.cmd = CMD_POLL;
          b.flag_max_retry = 1'b0;
          b.flag_sent = 1'b0;
        end
      endcase
      send_beat(b);
    end
    t_now = t_now + $urandom_range(0, tmo_limit / 2);
    b = rand_beat();
    b.cmd = CMD_POLL;
    b.now_us = t_now;
    case ($urandom_range(0, 3))
      0: b.flag_max_retry = 1'b1;
      1: begin
        b.flag_max_retry = 1'b0;
        b.flag_sent = 1'b1;
        b.fifo_empty = 1'b1;
      end
      2: begin
        {b.flag_max_retry, b.flag_sent} = 2'b00;
        t_now = trk_start + tmo_limit + $urandom_range(0, 1);
        b.now_us = t_now;
      end
      default: begin
        {b.flag_max_retry, b.flag_sent} = 2'b00;
        t_now = trk_start + tmo_limit + $urandom_range(1, 5000);
        b.now_us = t_now;
      end
    endcase
    send_beat(b);
    if ($urandom_range(0, 2) != 0) begin
      b = rand_beat();
      b.cmd = CMD_ACK;
      b.now_us = t_now;
      send_beat(b);
    end
  endtask

  task automatic test_directed_cases();
    idle_on = 1'b1;
    rx_mode = RX_GAPPY;
    send_beat(poll_beat(32'd0, 1'b1, 1'b1, 1'b1, 4'hF, 4'hF));
    send_beat(cmd_beat(CMD_NOP, 32'hFFFF_FFFF));
    send_beat(push_beat(32'd10, 8'd0, 1'b0));
    send_beat(push_beat(32'd11, 8'd33, 1'b1));
    send_beat(push_beat(32'd12, 8'd255, 1'b0));
    send_beat(push_beat(32'd13, MAX_PAYLOAD, 1'b1));
    send_beat(push_beat(32'hFFFF_FF00, 8'd1, 1'b0));
    send_beat(push_beat(32'hFFFF_FFFF, MAX_PAYLOAD, 1'b0));
    send_beat(poll_beat(32'hFFFF_FF00 + 32'd20000, 1'b0, 1'b0, 1'b1, 4'hF, 4'hF));
    send_beat(poll_beat(32'd30000, 1'b1, 1'b1, 1'b1, 4'hF, 4'hF));
    send_beat(poll_beat(32'd30001, 1'b1, 1'b0, 1'b0, 4'h3, 4'h3));
    send_beat(push_beat(32'd0, 8'd16, 1'b0));
    send_beat(poll_beat(32'd100, 1'b0, 1'b1, 1'b0, 4'hF, 4'h0));
    send_beat(poll_beat(32'd200, 1'b0, 1'b1, 1'b1, 4'h0, 4'hF));
    send_beat(push_beat(32'd1000, 8'd2, 1'b0));
    send_beat(poll_beat(32'd21001, 1'b0, 1'b0, 1'b0, 4'h5, 4'h5));
    send_beat(cmd_beat(CMD_ACK, 32'd21002));
    send_beat(cmd_beat(CMD_ACK, 32'd21003));
    send_beat(push_beat(32'hFFFF_FFFF, 8'd8, 1'b0));
    send_beat(cmd_beat(CMD_ACK, 32'd0));
    send_beat(push_beat(32'd5, 8'd4, 1'b0));
    send_beat(cmd_beat(CMD_NOP, 32'd6));
    send_beat(poll_beat(32'd7, 1'b1, 1'b0, 1'b0, 4'h0, 4'h0));
    send_beat(cmd_beat(CMD_ACK, 32'd8));
  endtask

  task automatic test_timeout_register();
    logic [TIMEOUT_W-1:0] pick [4];
    pick[0] = '0;
    pick[1] = '1;
    pick[2] = 1;
    pick[3] = $urandom_range(2, 131070);
    idle_on = 1'b0;
    rx_mode = RX_GAPPY;
    foreach (pick[i]) begin
      set_timeout(pick[i]);
      t_now = $urandom;
      send_beat(push_beat(t_now, 8'd1, 1'b0));
      send_beat(poll_beat(t_now + pick[i], 1'b0, 1'b0, 1'b0, 4'h0, 4'h0));
      send_beat(poll_beat(t_now + pick[i] + 1, 1'b0, 1'b0, 1'b0, 4'h0, 4'h0));
      send_beat(cmd_beat(CMD_ACK, t_now));
      send_beat(push_beat(t_now, 8'd1, 1'b0));
      send_beat(poll_beat(t_now + 32'h8000_0000, 1'b0, 1'b0, 1'b0, 4'h0, 4'h0));
      send_beat(cmd_beat(CMD_ACK, t_now));
    end
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    rx_mode = RX_CHOKED;
    repeat (6) run_transaction();
    drain_reports();
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_timeout('1);
          t_now = 32'hFFF0_0000;
          idle_on = 1'b1;
          rx_mode = RX_GAPPY;
        end
        1: begin
          set_timeout($urandom_range(1, 2000));
          t_now = $urandom;
          idle_on = 1'b1;
          rx_mode = RX_GAPPY;
        end
        2: begin
          set_timeout('0);
          idle_on = 1'b0;
          rx_mode = RX_ALWAYS;
        end
        default: begin
          set_timeout(TIMEOUT_RESET);
          idle_on = 1'b1;
          rx_mode = RX_CHOKED;
        end
      endcase
      stop_at = beats_sent + 95;
      while (beats_sent < stop_at) begin
        if ($urandom_range(0, 9) < 8) run_transaction();
        else send_beat(rand_beat());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_timeout_register();
    test_backpressure();
    test_random_traffic();
    drain_reports();
    repeat (8) @(posedge clk);
    if (report_q.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected results never arrived", $time, report_q.size());
    end
    $display("Sent %0d beats, checked %0d results over %0d timeout settings.",
             beats_sent, results_seen, settings_used);
    $display("Tracker totals: %0d ok, %0d dropped, %0d timed out, %0d retransmits.",
             ok_sum, drop_sum, tmo_sum, retx_sum);
    if (err_count == 0) begin
      $display("** radio_tx_completion_tracker_top: PASSED **");
    end else begin
      $display("** radio_tx_completion_tracker_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: run timed out", $time);
    $display("** radio_tx_completion_tracker_top: FAILED **");
    $finish;
  end

endmodule
